/* hdl/v3a_pkg.sv */
`timescale 1ns / 1ps
package v3a_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned WordBits = 32;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_SCALE = 3'd3,
    OP_DOT   = 3'd4,
    OP_CROSS = 3'd5,
    OP_LEN   = 3'd6,
    OP_NORM  = 3'd7
  } op_e;

  // one queued transaction between the front and back parts
  typedef struct packed {
    op_e                op;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by_comp;
    logic signed [31:0] bz;
    logic signed [31:0] factor;
  } item_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] scalar_out;
    logic               zero_length;
    logic               overflow;
  } res_t;

  localparam logic signed [31:0] SatMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] SatMin = 32'sh8000_0000;

  // saturate a 68 bit signed value to 32 bits
  function automatic logic [32:0] sat68(input logic signed [67:0] v);
    logic [32:0] r;
    if (v > 68'(SatMax))      r = {1'b1, SatMax};
    else if (v < 68'(SatMin)) r = {1'b1, SatMin};
    else                      r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage

/* hdl/v3a_queue.sv */
`timescale 1ns / 1ps
module v3a_queue import v3a_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  stall_i,
  output item_t item_o
);

  // two entry queue, registered stall on the input side
  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign stall_o = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];
  assign push    = valid_i & ~stall_o;
  assign pop     = valid_o & ~stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item_i;
  end

endmodule

/* hdl/v3a_back.sv */
`timescale 1ns / 1ps
module v3a_back import v3a_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  stall_i,
  output res_t  res_o
);

  // pipeline: s1 products, s2 sums, s3..s35 isqrt (one bit per stage),
  // then 48 stage restoring divider, then output
  localparam int unsigned SqBits  = 33;   // isqrt result bits (sum < 2^66)
  localparam int unsigned SqSteps = 33;
  localparam int unsigned DivBits = 48;   // quotient bits of (|a|<<16)/L
  localparam int unsigned Depth   = 2 + SqSteps + DivBits + 1;

  // all stages advance together when the output is free
  logic adv;
  logic [Depth-1:0] v_q;
  assign adv     = ~(v_q[Depth-1] & stall_i);
  assign stall_o = ~adv;
  assign valid_o = v_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[Depth-2:0], valid_i};
  end

  // stage 1: products
  typedef struct packed {
    op_e                op;
    logic signed [32:0] sx, sy, sz;  // add/sub
    logic signed [63:0] p0, p1, p2, p3, p4, p5;
    logic [63:0]        m0, m1, m2;  // squares of magnitudes
    logic [31:0]        ux, uy, uz;  // magnitudes
    logic               nx, ny, nz;
  } s1_t;
  s1_t s1_q;
  s1_t s1_d;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  always_comb begin
    s1_d    = '0;
    s1_d.op = item_i.op;
    s1_d.ux = mag32(item_i.ax);
    s1_d.uy = mag32(item_i.ay);
    s1_d.uz = mag32(item_i.az);
    s1_d.nx = item_i.ax[31];
    s1_d.ny = item_i.ay[31];
    s1_d.nz = item_i.az[31];
    s1_d.m0 = s1_d.ux * s1_d.ux;
    s1_d.m1 = s1_d.uy * s1_d.uy;
    s1_d.m2 = s1_d.uz * s1_d.uz;
    if (item_i.op == OP_SUB) begin
      s1_d.sx = 33'(item_i.ax) - 33'(item_i.bx);
      s1_d.sy = 33'(item_i.ay) - 33'(item_i.by_comp);
      s1_d.sz = 33'(item_i.az) - 33'(item_i.bz);
    end else begin
      s1_d.sx = 33'(item_i.ax) + 33'(item_i.bx);
      s1_d.sy = 33'(item_i.ay) + 33'(item_i.by_comp);
      s1_d.sz = 33'(item_i.az) + 33'(item_i.bz);
    end
    case (item_i.op)
      OP_SCALE: begin
        s1_d.p0 = item_i.ax * item_i.factor;
        s1_d.p1 = item_i.ay * item_i.factor;
        s1_d.p2 = item_i.az * item_i.factor;
      end
      OP_CROSS: begin
        s1_d.p0 = item_i.ay * item_i.bz;
        s1_d.p1 = item_i.az * item_i.bx;
        s1_d.p2 = item_i.ax * item_i.by_comp;
        s1_d.p3 = item_i.az * item_i.by_comp;
        s1_d.p4 = item_i.ax * item_i.bz;
        s1_d.p5 = item_i.ay * item_i.bx;
      end
      default: begin
        s1_d.p0 = item_i.ax * item_i.bx;
        s1_d.p1 = item_i.ay * item_i.by_comp;
        s1_d.p2 = item_i.az * item_i.bz;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) s1_q <= s1_d;
  end

  // stage 2: sums, floor shift, saturation for non-root ops
  typedef struct packed {
    op_e         op;
    res_t        res;
    logic [65:0] sq;
    logic [31:0] ux, uy, uz;
    logic        nx, ny, nz;
  } s2_t;
  s2_t s2_q, s2_d;

  always_comb begin
    logic signed [67:0] vx, vy, vz;
    logic [32:0] tx, ty, tz;
    s2_d    = '0;
    s2_d.op = s1_q.op;
    s2_d.ux = s1_q.ux;
    s2_d.uy = s1_q.uy;
    s2_d.uz = s1_q.uz;
    s2_d.nx = s1_q.nx;
    s2_d.ny = s1_q.ny;
    s2_d.nz = s1_q.nz;
    s2_d.sq = 66'(s1_q.m0) + 66'(s1_q.m1) + 66'(s1_q.m2);
    vx = '0;
    vy = '0;
    vz = '0;
    // arithmetic shift of the exact sum is the floor
    case (s1_q.op)
      OP_ADD, OP_SUB: begin
        vx = 68'(s1_q.sx);
        vy = 68'(s1_q.sy);
        vz = 68'(s1_q.sz);
      end
      OP_MUL, OP_SCALE: begin
        vx = 68'(s1_q.p0) >>> FracBits;
        vy = 68'(s1_q.p1) >>> FracBits;
        vz = 68'(s1_q.p2) >>> FracBits;
      end
      OP_DOT: begin
        vx = (68'(s1_q.p0) + 68'(s1_q.p1) + 68'(s1_q.p2)) >>> FracBits;
      end
      OP_CROSS: begin
        vx = (68'(s1_q.p0) - 68'(s1_q.p3)) >>> FracBits;
        vy = (68'(s1_q.p1) - 68'(s1_q.p4)) >>> FracBits;
        vz = (68'(s1_q.p2) - 68'(s1_q.p5)) >>> FracBits;
      end
      default: ;
    endcase
    tx = sat68(vx);
    ty = sat68(vy);
    tz = sat68(vz);
    if (s1_q.op == OP_DOT) begin
      s2_d.res.scalar_out = tx[31:0];
      s2_d.res.overflow   = tx[32];
    end else begin
      s2_d.res.rx       = tx[31:0];
      s2_d.res.ry       = ty[31:0];
      s2_d.res.rz       = tz[31:0];
      s2_d.res.overflow = tx[32] | ty[32] | tz[32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) s2_q <= s2_d;
  end

  // isqrt pipeline: one result bit per stage, restoring
  typedef struct packed {
    op_e         op;
    res_t        res;
    logic [65:0] rem;
    logic [SqBits-1:0] root;
    logic [31:0] ux, uy, uz;
    logic        nx, ny, nz;
  } sq_t;
  sq_t sq0;
  sq_t sq_q [1:SqSteps];

  always_comb begin
    sq0      = '0;
    sq0.op   = s2_q.op;
    sq0.res  = s2_q.res;
    sq0.rem  = s2_q.sq;
    sq0.ux   = s2_q.ux;
    sq0.uy   = s2_q.uy;
    sq0.uz   = s2_q.uz;
    sq0.nx   = s2_q.nx;
    sq0.ny   = s2_q.ny;
    sq0.nz   = s2_q.nz;
  end

  for (genvar g = 0; g < SqSteps; g++) begin : g_sq
    localparam int unsigned Bit = SqSteps - 1 - g;
    sq_t src, d;
    if (g == 0) begin : g_first
      assign src = sq0;
    end else begin : g_next
      assign src = sq_q[g];
    end
    always_comb begin
      logic [67:0] trial;
      d = src;
      // (root + 2^bit)^2 - root^2 = 2^bit*(2*root + 2^bit)
      trial = (68'(src.root) << (Bit + 1)) + (68'(1) << (2 * Bit));
      if (68'(src.rem) >= trial) begin
        d.rem  = 66'(68'(src.rem) - trial);
        d.root = src.root | (SqBits'(1) << Bit);
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) sq_q[g+1] <= d;
    end
  end

  // length result and divider setup
  typedef struct packed {
    op_e         op;
    res_t        res;
    logic [SqBits-1:0] len;
    logic [47:0] qx, qy, qz;       // dividends shift into quotients
    logic [SqBits:0] rx, ry, rz;   // partial remainders
    logic        nx, ny, nz;
  } dv_t;
  dv_t dv0;
  dv_t dv_q [1:DivBits];

  always_comb begin
    dv0      = '0;
    dv0.op   = sq_q[SqSteps].op;
    dv0.res  = sq_q[SqSteps].res;
    dv0.len  = sq_q[SqSteps].root;
    dv0.qx   = {sq_q[SqSteps].ux, 16'd0};
    dv0.qy   = {sq_q[SqSteps].uy, 16'd0};
    dv0.qz   = {sq_q[SqSteps].uz, 16'd0};
    dv0.nx   = sq_q[SqSteps].nx;
    dv0.ny   = sq_q[SqSteps].ny;
    dv0.nz   = sq_q[SqSteps].nz;
  end

  function automatic logic [SqBits+48:0] div_step(input logic [SqBits:0] r,
      input logic [47:0] q, input logic [SqBits-1:0] l);
    logic [SqBits+1:0] t;
    logic [SqBits:0]   nr;
    t  = {r, q[47]};
    nr = '0;
    if (t >= (SqBits+2)'(l)) begin
      nr = (SqBits+1)'(t - (SqBits+2)'(l));
      return {nr, q[46:0], 1'b1};
    end
    nr = (SqBits+1)'(t);
    return {nr, q[46:0], 1'b0};
  endfunction

  for (genvar g = 0; g < DivBits; g++) begin : g_dv
    dv_t src, d;
    if (g == 0) begin : g_first
      assign src = dv0;
    end else begin : g_next
      assign src = dv_q[g];
    end
    always_comb begin
      d = src;
      {d.rx, d.qx} = div_step(src.rx, src.qx, src.len);
      {d.ry, d.qy} = div_step(src.ry, src.qy, src.len);
      {d.rz, d.qz} = div_step(src.rz, src.qz, src.len);
    end
    always_ff @(posedge clk_i) begin
      if (adv) dv_q[g+1] <= d;
    end
  end

  // final stage: pick result
  res_t out_q, out_d;
  dv_t  fin;
  assign fin = dv_q[DivBits];

  function automatic logic [32:0] sat_q(input logic [47:0] q, input logic n);
    logic signed [67:0] v;
    v = n ? -68'(q) : 68'(q);
    return sat68(v);
  endfunction

  always_comb begin
    logic [32:0] tx, ty, tz;
    tx = sat_q(fin.qx, fin.nx);
    ty = sat_q(fin.qy, fin.ny);
    tz = sat_q(fin.qz, fin.nz);
    out_d = fin.res;
    if (fin.op == OP_LEN) begin
      out_d = '0;
      if (fin.len > SqBits'(SatMax)) begin
        out_d.scalar_out = SatMax;
        out_d.overflow   = 1'b1;
      end else begin
        out_d.scalar_out = fin.len[31:0];
      end
    end else if (fin.op == OP_NORM) begin
      out_d = '0;
      if (fin.len == '0) begin
        out_d.zero_length = 1'b1;
      end else begin
        out_d.rx       = tx[31:0];
        out_d.ry       = ty[31:0];
        out_d.rz       = tz[31:0];
        out_d.overflow = tx[32] | ty[32] | tz[32];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign res_o = out_q;

endmodule

/* hdl/vec3_alu.sv */
`timescale 1ns / 1ps
// channel  valid      stall      payload
// in       valid_i    stall_o    op_i ax_i ay_i az_i bx_i by_comp_i bz_i factor_i
// out      valid_o    stall_i    rx_o ry_o rz_o scalar_out_o zero_length_o overflow_o
//
// one transaction per cycle sustained while the output is not stalled; each
// transaction passes one queue entry and then the back pipeline, whose depth is
// set by the 33 stage square root and the 48 stage divider
// a two entry queue parts the front from the back, so stalls do not ripple
// combinationally to the input; the back pipeline freezes as a whole when
// its output is held
// reset clears control state only (valid flags, queue count and pointers)
module vec3_alu import v3a_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] ax_i,
  input  logic signed [31:0] ay_i,
  input  logic signed [31:0] az_i,
  input  logic signed [31:0] bx_i,
  input  logic signed [31:0] by_comp_i,
  input  logic signed [31:0] bz_i,
  input  logic signed [31:0] factor_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] rx_o,
  output logic signed [31:0] ry_o,
  output logic signed [31:0] rz_o,
  output logic signed [31:0] scalar_out_o,
  output logic               zero_length_o,
  output logic               overflow_o
);

  item_t in_item, q_item;
  logic  q_valid, q_stall;
  res_t  res;

  always_comb begin
    in_item.op      = op_e'(op_i);
    in_item.ax      = ax_i;
    in_item.ay      = ay_i;
    in_item.az      = az_i;
    in_item.bx      = bx_i;
    in_item.by_comp = by_comp_i;
    in_item.bz      = bz_i;
    in_item.factor  = factor_i;
  end

  v3a_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .item_i  (in_item),
    .valid_o (q_valid),
    .stall_i (q_stall),
    .item_o  (q_item)
  );

  v3a_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .stall_o (q_stall),
    .item_i  (q_item),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .res_o   (res)
  );

  assign rx_o          = res.rx;
  assign ry_o          = res.ry;
  assign rz_o          = res.rz;
  assign scalar_out_o  = res.scalar_out;
  assign zero_length_o = res.zero_length;
  assign overflow_o    = res.overflow;

  a_zl_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && zero_length_o |-> !overflow_o && rx_o == 0 && ry_o == 0 && rz_o == 0)
    else $error("zero length result carries data");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && scalar_out_o != 0 |-> rx_o == 0 && ry_o == 0 && rz_o == 0)
    else $error("scalar and vector result both set");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(rx_o) && $stable(scalar_out_o))
    else $error("held result changed");

endmodule
